// ----- rtl/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types, register map constants and the alias update helper for the
// cluster power controller register file.
// ----------------------------------------------------------------------------
package cpc_pkg;

  // Register map
  localparam logic [14:0] CORE_AREA_END = 15'h0400;
  localparam logic [14:0] ADDR_WAKE     = 15'h1000;
  localparam logic [14:0] ADDR_WAKE_SET = 15'h1010;
  localparam logic [14:0] ADDR_WAKE_CLR = 15'h1020;
  localparam logic [14:0] ADDR_ROW      = 15'h1040;
  localparam logic [14:0] ADDR_ROW_SET  = 15'h1050;
  localparam logic [14:0] ADDR_ROW_CLR  = 15'h1060;
  localparam logic [14:0] ADDR_PC       = 15'h2000;
  localparam logic [14:0] ADDR_GLB      = 15'h4040;
  localparam logic [14:0] ADDR_GLB_SET  = 15'h4050;
  localparam logic [14:0] ADDR_GLB_CLR  = 15'h4060;
  localparam logic [14:0] ADDR_RES      = 15'h40C0;
  localparam logic [14:0] ADDR_RES_SET  = 15'h40D0;
  localparam logic [14:0] ADDR_RES_CLR  = 15'h40E0;

  // Per-core sub-offsets inside the 0x40 stride
  localparam logic [5:0] SUB_PLAIN = 6'h00;
  localparam logic [5:0] SUB_SET   = 6'h10;
  localparam logic [5:0] SUB_CLR   = 6'h20;

  // Write masks and reset values
  localparam logic [63:0] CTRL_MASK    = 64'h0000_0000_0000_0403;
  localparam logic [63:0] VEC_MASK     = 64'h0000_0000_0000_ffff;
  localparam logic [63:0] GLB_MASK     = 64'h8000_007e_ffff_ff0f;
  localparam logic [63:0] GLB_RESET    = 64'h0000_0008_ffff_ff00;
  localparam logic [63:0] PC_ALIGN     = 64'h0000_0000_0000_0fff;
  localparam int          PE_EN_BIT    = 1;

  localparam int CTRL_W = 11;
  localparam int VEC_W  = 16;

  // Alias codes (address bits [5:4])
  localparam logic [1:0] OP_PLAIN = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLR   = 2'd2;

  // Register selected by an access
  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_CORE,
    SEL_WAKE,
    SEL_ROW,
    SEL_PC,
    SEL_GLB,
    SEL_RES
  } cpc_sel_t;

  typedef struct packed {
    cpc_sel_t   sel;
    logic [1:0] op;
    logic [3:0] core;
  } cpc_dec_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        wake_valid;
    logic [15:0] wake_mask;
    logic [63:0] wake_pc;
  } cpc_result_t;

  // Plain / set / clear update of a masked register
  function automatic logic [63:0] apply_op(input logic [63:0] cur,
                                           input logic [63:0] val,
                                           input logic [63:0] mask,
                                           input logic [1:0]  op);
    logic [63:0] m;
    m = val & mask;
    case (op)
      OP_PLAIN: apply_op = m;
      OP_SET:   apply_op = cur | m;
      default:  apply_op = cur & ~m;
    endcase
  endfunction

endpackage

// ----- rtl/cluster_power_ctrl_regs.sv -----
// ----------------------------------------------------------------------------
// cluster_power_ctrl_regs
// Register file of a cluster power controller with wake pulse generation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one beat per 64-bit bus access, read or write.
//   Result channel (out_*): one beat per access, in order, carrying the read
//   data (zero for writes and unmapped offsets) and the wake pulse fields.
//   Both channels use valid/stall; a beat moves when valid is high and
//   stall is low.
//   An accepted access reaches out_* through the input register, then the
//   result register. Throughput: one access per cycle while out_stall is
//   low; decode, alias update and read mux fit between the two registers.
//   Register state is updated when an access moves into the result register.
//   Reset (rst_n low, synchronous) empties both stages and loads register
//   reset values. When the receiver stalls, the result holds; one more access
//   waits in the input register, after which in_stall is raised.
// ----------------------------------------------------------------------------
module cluster_power_ctrl_regs
  import cpc_pkg::*;
#(
  parameter int NUM_CORES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [14:0] in_address,
  input  logic [63:0] in_write_data,
  input  logic [15:0] in_cores_resetting,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_read_data,
  output logic        out_wake_valid,
  output logic [15:0] out_wake_mask,
  output logic [63:0] out_wake_pc
);

  logic        s1_v_r, s1_v_nxt;
  logic        s1_wr_r;
  logic [14:0] s1_addr_r;
  logic [63:0] s1_data_r;
  logic [15:0] s1_rst_r;
  logic        out_v_nxt;
  logic        in_acc;
  logic        s1_fire;
  cpc_dec_t    dec;
  cpc_result_t res;
  cpc_result_t out_r;

  // handshake
  assign s1_fire  = s1_v_r && !(out_valid && out_stall);
  assign in_stall = s1_v_r && !s1_fire;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) s1_v_nxt = 1'b1;
    else if (s1_fire) s1_v_nxt = 1'b0;
    out_v_nxt = out_valid;
    if (s1_fire) out_v_nxt = 1'b1;
    else if (!out_stall) out_v_nxt = 1'b0;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_wr_r   <= in_req_type;
      s1_addr_r <= in_address;
      s1_data_r <= in_write_data;
      s1_rst_r  <= in_cores_resetting;
    end
  end

  cpc_decode #(.NUM_CORES(NUM_CORES)) u_decode (
    .address (s1_addr_r),
    .dec     (dec)
  );

  cpc_regs #(.NUM_CORES(NUM_CORES)) u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (s1_fire),
    .dec             (dec),
    .is_write        (s1_wr_r),
    .write_data      (s1_data_r),
    .cores_resetting (s1_rst_r),
    .res             (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) out_r <= res;
  end

  assign out_read_data  = out_r.read_data;
  assign out_wake_valid = out_r.wake_valid;
  assign out_wake_mask  = out_r.wake_mask;
  assign out_wake_pc    = out_r.wake_pc;

`ifndef SYNTHESIS
  // a wake pulse only comes from a write, so read data is zero
  a_wake_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_valid |-> out_read_data == 64'd0)
    else $error("wake beat carries read data");

  // without a wake pulse the wake fields are zero
  a_nowake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_wake_valid |-> out_wake_mask == 16'd0 && out_wake_pc == 64'd0)
    else $error("wake fields set without wake pulse");

  // reset PC is always 4 KiB aligned
  a_pc_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_wake_pc[11:0] == 12'd0)
    else $error("wake pc not aligned");

  // input stage only stalls when it is full and the result is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && out_valid && out_stall)
    else $error("spurious input stall");
`endif

endmodule

// ----- rtl/cpc_decode.sv -----
// ----------------------------------------------------------------------------
// cpc_decode
// Address decode: picks the target register, alias and core index.
// ----------------------------------------------------------------------------
module cpc_decode
  import cpc_pkg::*;
#(
  parameter int NUM_CORES = 16
) (
  input  logic [14:0] address,
  output cpc_dec_t    dec
);

  logic [3:0] core_idx;
  logic [5:0] sub;

  assign core_idx = address[9:6];
  assign sub      = address[5:0];

  always_comb begin
    dec.sel  = SEL_NONE;
    dec.op   = address[5:4];
    dec.core = core_idx;
    if (address < CORE_AREA_END) begin
      // per-core window: only +0x00/+0x10/+0x20 of existing cores
      if ((32'(core_idx) < NUM_CORES) &&
          (sub == SUB_PLAIN || sub == SUB_SET || sub == SUB_CLR)) begin
        dec.sel = SEL_CORE;
      end
    end else begin
      case (address)
        ADDR_WAKE, ADDR_WAKE_SET, ADDR_WAKE_CLR: dec.sel = SEL_WAKE;
        ADDR_ROW, ADDR_ROW_SET, ADDR_ROW_CLR:    dec.sel = SEL_ROW;
        ADDR_PC:                                 dec.sel = SEL_PC;
        ADDR_GLB, ADDR_GLB_SET, ADDR_GLB_CLR:    dec.sel = SEL_GLB;
        ADDR_RES, ADDR_RES_SET, ADDR_RES_CLR:    dec.sel = SEL_RES;
        default:                                 dec.sel = SEL_NONE;
      endcase
    end
  end

endmodule

// ----- rtl/cpc_regs.sv -----
// ----------------------------------------------------------------------------
// cpc_regs
// Register storage, alias update, read mux and wake evaluation.
// ----------------------------------------------------------------------------
module cpc_regs
  import cpc_pkg::*;
#(
  parameter int NUM_CORES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  cpc_dec_t    dec,
  input  logic        is_write,
  input  logic [63:0] write_data,
  input  logic [15:0] cores_resetting,
  output cpc_result_t res
);

  localparam logic [15:0] CORE_MASK = 16'((32'd1 << NUM_CORES) - 32'd1);

  logic [CTRL_W-1:0] core_ctrl_r [NUM_CORES];
  logic [VEC_W-1:0]  wake_r, wake_nxt;
  logic [VEC_W-1:0]  row_r, row_nxt;
  logic [63:0]       pc_r, pc_nxt;
  logic [63:0]       glb_r, glb_nxt;
  logic [CTRL_W-1:0] res_r, res_nxt;
  logic [CTRL_W-1:0] core_sel;
  logic [CTRL_W-1:0] core_nxt;
  logic [63:0]       rd;
  logic              wake;

  // selected core entry
  always_comb begin
    core_sel = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      if (dec.core == 4'(i)) core_sel = core_ctrl_r[i];
    end
  end

  // next values for the addressed register
  always_comb begin
    wake_nxt = wake_r;
    row_nxt  = row_r;
    pc_nxt   = pc_r;
    glb_nxt  = glb_r;
    res_nxt  = res_r;
    core_nxt = CTRL_W'(apply_op(64'(core_sel), write_data, CTRL_MASK, dec.op));
    if (is_write) begin
      case (dec.sel)
        SEL_WAKE: wake_nxt = VEC_W'(apply_op(64'(wake_r), write_data, VEC_MASK, dec.op));
        SEL_ROW:  row_nxt  = VEC_W'(apply_op(64'(row_r), write_data, VEC_MASK, dec.op));
        SEL_PC:   pc_nxt   = write_data & ~PC_ALIGN;
        SEL_GLB:  glb_nxt  = apply_op(glb_r, write_data, GLB_MASK, dec.op);
        SEL_RES:  res_nxt  = CTRL_W'(apply_op(64'(res_r), write_data, CTRL_MASK, dec.op));
        default:  ;
      endcase
    end
  end

  // read mux: only plain aliases read back
  always_comb begin
    rd = '0;
    if (!is_write) begin
      case (dec.sel)
        SEL_CORE: if (dec.op == OP_PLAIN) rd = 64'(core_sel);
        SEL_WAKE: if (dec.op == OP_PLAIN) rd = 64'(wake_r);
        SEL_ROW:  if (dec.op == OP_PLAIN) rd = 64'(row_r);
        SEL_PC:   rd = pc_r;
        SEL_GLB:  if (dec.op == OP_PLAIN) rd = glb_r;
        SEL_RES:  if (dec.op == OP_PLAIN) rd = 64'(res_r);
        default:  rd = '0;
      endcase
    end
  end

  // wake pulse on plain/set write with core enable set
  assign wake = is_write && (dec.sel == SEL_WAKE) && (dec.op != OP_CLR) && glb_r[PE_EN_BIT];

  always_comb begin
    res.read_data  = rd;
    res.wake_valid = wake;
    res.wake_mask  = wake ? (wake_nxt & cores_resetting & CORE_MASK) : '0;
    res.wake_pc    = wake ? pc_r : '0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wake_r <= '0;
      row_r  <= '0;
      pc_r   <= '0;
      glb_r  <= GLB_RESET;
      res_r  <= '0;
      for (int i = 0; i < NUM_CORES; i++) core_ctrl_r[i] <= '0;
    end else if (en) begin
      wake_r <= wake_nxt;
      row_r  <= row_nxt;
      pc_r   <= pc_nxt;
      glb_r  <= glb_nxt;
      res_r  <= res_nxt;
      for (int i = 0; i < NUM_CORES; i++) begin
        if (is_write && dec.sel == SEL_CORE && dec.core == 4'(i)) core_ctrl_r[i] <= core_nxt;
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cluster power controller register file. Bus
// accesses are driven over the valid/stall input channel with random gaps,
// and the result channel is stalled at random. An in-bench register model
// predicts the read data and the wake pulse fields for every accepted beat,
// and each result beat is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import cpc_pkg::*;

  localparam int NUM_CORES    = 16;
  localparam int ITEMS        = 1500;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_WAIT     = 14;
  localparam int DRAIN_CYCLES = 8;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Register model and the queue of result beats it predicts
  class cpc_scoreboard;
    logic [CTRL_W-1:0] core_ctrl [NUM_CORES];
    logic [VEC_W-1:0]  wake_vec;
    logic [VEC_W-1:0]  row_vec;
    logic [63:0]       pc_reg;
    logic [63:0]       glb_reg;
    logic [CTRL_W-1:0] res_reg;
    cpc_result_t       due_results [$];
    int                errors;
    int                n_access;
    int                n_read;
    int                n_wake;

    function new();
      for (int i = 0; i < NUM_CORES; i++) core_ctrl[i] = '0;
      wake_vec = '0;
      row_vec  = '0;
      pc_reg   = '0;
      glb_reg  = GLB_RESET;
      res_reg  = '0;
      errors   = 0;
      n_access = 0;
      n_read   = 0;
      n_wake   = 0;
    endfunction

    // plain replaces, set ORs in, clear knocks out the masked bits
    function logic [63:0] merge_alias(logic [63:0] cur, logic [63:0] val,
                                      logic [63:0] mask, logic [1:0] op);
      logic [63:0] bits;
      bits = val & mask;
      if (op == OP_PLAIN) return bits;
      if (op == OP_SET) return cur | bits;
      return cur & ~bits;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Update the model with one accepted access and queue its result beat
    function void note_access(logic is_write, logic [14:0] addr, logic [63:0] data,
                              logic [15:0] resetting);
      cpc_result_t r;
      logic [1:0]  op;
      logic [3:0]  core;
      logic [63:0] rd;
      logic        wake;
      logic [15:0] present;
      op      = addr[5:4];  // alias code sits in address bits 5:4 everywhere
      core    = addr[9:6];
      rd      = '0;
      wake    = 1'b0;
      present = 16'((32'h1 << NUM_CORES) - 1);
      if (addr < CORE_AREA_END) begin
        if (int'(core) < NUM_CORES &&
            (addr[5:0] == SUB_PLAIN || addr[5:0] == SUB_SET || addr[5:0] == SUB_CLR)) begin
          if (is_write) begin
            core_ctrl[core] = CTRL_W'(merge_alias(64'(core_ctrl[core]), data, CTRL_MASK, op));
          end else if (op == OP_PLAIN) begin
            rd = 64'(core_ctrl[core]);
          end
        end
      end else begin
        case (addr)
          ADDR_WAKE, ADDR_WAKE_SET, ADDR_WAKE_CLR: begin
            if (is_write) begin
              wake_vec = VEC_W'(merge_alias(64'(wake_vec), data, VEC_MASK, op));
              wake = (op != OP_CLR) && glb_reg[PE_EN_BIT];
            end else if (op == OP_PLAIN) begin
              rd = 64'(wake_vec);
            end
          end
          ADDR_ROW, ADDR_ROW_SET, ADDR_ROW_CLR: begin
            if (is_write) row_vec = VEC_W'(merge_alias(64'(row_vec), data, VEC_MASK, op));
            else if (op == OP_PLAIN) rd = 64'(row_vec);
          end
          ADDR_PC: begin
            if (is_write) pc_reg = data & ~PC_ALIGN;
            else rd = pc_reg;
          end
          ADDR_GLB, ADDR_GLB_SET, ADDR_GLB_CLR: begin
            if (is_write) glb_reg = merge_alias(glb_reg, data, GLB_MASK, op);
            else if (op == OP_PLAIN) rd = glb_reg;
          end
          ADDR_RES, ADDR_RES_SET, ADDR_RES_CLR: begin
            if (is_write) res_reg = CTRL_W'(merge_alias(64'(res_reg), data, CTRL_MASK, op));
            else if (op == OP_PLAIN) rd = 64'(res_reg);
          end
          default: ;  // unmapped: writes dropped, reads return zero
        endcase
      end
      r.read_data  = is_write ? 64'd0 : rd;
      r.wake_valid = wake;
      r.wake_mask  = wake ? (wake_vec & resetting & present) : 16'd0;
      r.wake_pc    = wake ? pc_reg : 64'd0;
      due_results.push_back(r);
      n_access++;
      if (!is_write) n_read++;
      if (wake) n_wake++;
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_result(cpc_result_t got);
      cpc_result_t want;
      if (due_results.size() == 0) begin
        $error("result beat with no access outstanding");
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        errors++;
      end
      if (got.wake_valid !== want.wake_valid) begin
        $error("wake_valid: expected %b, got %b", want.wake_valid, got.wake_valid);
        errors++;
      end
      if (got.wake_mask !== want.wake_mask) begin
        $error("wake_mask: expected %h, got %h", want.wake_mask, got.wake_mask);
        errors++;
      end
      if (got.wake_pc !== want.wake_pc) begin
        $error("wake_pc: expected %h, got %h", want.wake_pc, got.wake_pc);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = REQ_READ;
  logic [14:0] in_address = '0;
  logic [63:0] in_write_data = '0;
  logic [15:0] in_cores_resetting = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [63:0] out_read_data;
  logic        out_wake_valid;
  logic [15:0] out_wake_mask;
  logic [63:0] out_wake_pc;

  bit calm_in  = 1'b0;
  bit calm_out = 1'b0;
  int cycles   = 0;

  cpc_scoreboard sb = new();

  cluster_power_ctrl_regs #(.NUM_CORES(NUM_CORES)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_address         (in_address),
    .in_write_data      (in_write_data),
    .in_cores_resetting (in_cores_resetting),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_data      (out_read_data),
    .out_wake_valid     (out_wake_valid),
    .out_wake_mask      (out_wake_mask),
    .out_wake_pc        (out_wake_pc)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Beat monitors on both channels, sampled on pre-edge values
  always @(posedge clk) begin
    cpc_result_t got;
    if (rst_n && in_valid && !in_stall) begin
      sb.note_access(in_req_type, in_address, in_write_data, in_cores_resetting);
    end
    if (rst_n && out_valid && !out_stall) begin
      got.read_data  = out_read_data;
      got.wake_valid = out_wake_valid;
      got.wake_mask  = out_wake_mask;
      got.wake_pc    = out_wake_pc;
      sb.check_result(got);
    end
  end

  // Result receiver: random stall before each beat, with calm stretches
  initial begin : result_sink
    int hold;
    forever begin
      hold = calm_out ? 0 : $urandom_range(0, MAX_WAIT);
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // Drive one access beat after a random gap; valid stays up afterwards
  task automatic send_access(input logic req, input logic [14:0] addr,
                             input logic [63:0] data, input logic [15:0] resetting);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, MAX_WAIT);
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_req_type        <= req;
    in_address         <= addr;
    in_write_data      <= data;
    in_cores_resetting <= resetting;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every predicted beat has come back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [14:0] core_addr(input int core, input logic [5:0] sub);
    return {5'd0, 4'(core), sub};
  endfunction

  function automatic logic [14:0] named_reg(input int idx);
    case (idx)
      0:       return ADDR_WAKE;
      1:       return ADDR_WAKE_SET;
      2:       return ADDR_WAKE_CLR;
      3:       return ADDR_ROW;
      4:       return ADDR_ROW_SET;
      5:       return ADDR_ROW_CLR;
      6:       return ADDR_PC;
      7:       return ADDR_GLB;
      8:       return ADDR_GLB_SET;
      9:       return ADDR_GLB_CLR;
      10:      return ADDR_RES;
      11:      return ADDR_RES_SET;
      default: return ADDR_RES_CLR;
    endcase
  endfunction

  initial begin : stimulus
    logic [14:0] addr;
    logic [63:0] data;
    logic [15:0] resetting;
    logic [5:0]  sub;
    logic        req;
    int          pick;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values
    send_access(REQ_READ, ADDR_GLB, '0, '0);
    send_access(REQ_READ, ADDR_WAKE, '0, '0);
    send_access(REQ_READ, ADDR_PC, '0, '0);
    send_access(REQ_READ, core_addr(0, SUB_PLAIN), '0, '0);

    // Per-core aliases, first and last core
    send_access(REQ_WRITE, core_addr(NUM_CORES - 1, SUB_PLAIN), '1, '1);
    send_access(REQ_READ, core_addr(NUM_CORES - 1, SUB_PLAIN), '0, '0);
    send_access(REQ_WRITE, core_addr(0, SUB_SET), '1, '0);
    send_access(REQ_WRITE, core_addr(0, SUB_CLR), 64'h401, '0);
    send_access(REQ_READ, core_addr(0, SUB_PLAIN), '0, '0);

    // Wake write with core enable clear: vector only, no pulse
    send_access(REQ_WRITE, ADDR_WAKE, '1, '1);
    send_access(REQ_WRITE, ADDR_GLB_SET, 64'(1) << PE_EN_BIT, '0);
    send_access(REQ_WRITE, ADDR_PC, '1, '0);
    send_access(REQ_READ, ADDR_PC, '0, '0);

    // Wake pulses from plain and set, none from clear
    send_access(REQ_WRITE, ADDR_WAKE, 64'h00ff, 16'h0f0f);
    send_access(REQ_WRITE, ADDR_WAKE_SET, 64'hff00, '1);
    send_access(REQ_WRITE, ADDR_WAKE_CLR, '1, '1);

    // Reset-on-wakeup aliases leave the wake vector alone
    send_access(REQ_WRITE, ADDR_ROW_SET, '1, '0);
    send_access(REQ_WRITE, ADDR_ROW_CLR, 64'h00ff, '0);
    send_access(REQ_READ, ADDR_ROW, '0, '0);
    send_access(REQ_READ, ADDR_WAKE, '0, '0);

    // Unmapped offsets: status, unaligned, bad per-core slot, top of space
    send_access(REQ_WRITE, CORE_AREA_END, '1, '1);
    send_access(REQ_READ, CORE_AREA_END, '0, '0);
    send_access(REQ_READ, ADDR_WAKE + 15'd4, '0, '0);
    send_access(REQ_WRITE, core_addr(3, 6'h30), '1, '0);
    send_access(REQ_READ, 15'h7fff, '0, '0);
    send_access(REQ_READ, ADDR_WAKE_SET, '0, '0);

    // Global and resource masks at both extremes
    send_access(REQ_WRITE, ADDR_GLB, '1, '0);
    send_access(REQ_READ, ADDR_GLB, '0, '0);
    send_access(REQ_WRITE, ADDR_GLB_CLR, '1, '0);
    send_access(REQ_WRITE, ADDR_RES, '1, '0);
    send_access(REQ_WRITE, ADDR_RES_CLR, 64'h3, '0);
    send_access(REQ_READ, ADDR_RES, '0, '0);

    wait_all_results();

    // Random accesses, mostly to mapped registers
    for (int i = 0; i < ITEMS; i++) begin
      if (i == ITEMS / 2) wait_all_results();
      pick = $urandom_range(0, 15);
      if (pick <= 4) begin
        case ($urandom_range(0, 9))
          0:       sub = 6'($urandom_range(0, 63));
          1, 2, 3: sub = SUB_SET;
          4, 5, 6: sub = SUB_CLR;
          default: sub = SUB_PLAIN;
        endcase
        addr = core_addr($urandom_range(0, NUM_CORES - 1), sub);
      end else if (pick <= 11) begin
        addr = named_reg($urandom_range(0, 12));
      end else if (pick <= 13) begin
        addr = 15'($urandom_range(0, 32767));
      end else if (pick == 14) begin
        addr = named_reg($urandom_range(0, 12)) + 15'($urandom_range(1, 15));
      end else begin
        addr = 15'($urandom_range(32'h400, 32'hfff));
      end
      req = ($urandom_range(0, 4) < 3) ? REQ_WRITE : REQ_READ;
      case ($urandom_range(0, 15))
        0:       data = '0;
        1:       data = '1;
        default: data = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 7))
        0:       resetting = '0;
        1:       resetting = '1;
        default: resetting = 16'($urandom_range(0, 16'hffff));
      endcase
      send_access(req, addr, data, resetting);
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d accesses (%0d reads), %0d wake pulses, %0d mismatches",
             sb.n_access, sb.n_read, sb.n_wake, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cpc_pkg.sv
rtl/cpc_decode.sv
rtl/cpc_regs.sv
rtl/cluster_power_ctrl_regs.sv
tb/tb_top.sv
